>>> src/sst_pkg.sv
// ----------------------------------------------------------------------------
// Sorted set toggle package
// Shared constants, codes and payload types of the sorted set toggle block.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int VALUE_W  = 32;
    localparam int RIDX_W   = 6;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    localparam logic ACT_TOGGLE = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_READ     = 2'd3;

    typedef struct packed {
        logic                       action;
        logic signed [VALUE_W-1:0]  value;
        logic        [RIDX_W-1:0]   read_index;
    } cmd_t;

    typedef struct packed {
        logic        [STATUS_W-1:0] status;
        logic        [POS_W-1:0]    position;
        logic signed [VALUE_W-1:0]  entry_value;
        logic        [COUNT_W-1:0]  count;
    } rsp_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ctrl_stat_t;

endpackage

>>> src/sst_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/sst_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted set toggle sequencer
// Binary search over the entry RAM with one shared signed comparator, then
// an entry-by-entry move to open or close a gap; a read fetches one entry.
// ----------------------------------------------------------------------------
module sst_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  sst_pkg::cmd_t               cmd,
    input  logic                        res_ready,
    output sst_pkg::ctrl_stat_t         stat,
    output sst_pkg::rsp_t               res,
    output logic                        ram_we,
    output logic [sst_pkg::IDX_W-1:0]   ram_waddr,
    output logic [sst_pkg::VALUE_W-1:0] ram_wdata,
    output logic [sst_pkg::IDX_W-1:0]   ram_raddr,
    input  logic [sst_pkg::VALUE_W-1:0] ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_SRCH,
        S_CMP,
        S_MV_RD,
        S_MV_WR,
        S_PUT,
        S_DONE
    } state_t;

    state_t                            state_reg;
    logic                              is_del_reg;
    logic signed [sst_pkg::VALUE_W-1:0] val_reg;
    logic [sst_pkg::CNT_W-1:0]         cnt_reg;
    logic [sst_pkg::CNT_W-1:0]         lo_reg;
    logic [sst_pkg::CNT_W-1:0]         hi_reg;
    logic [sst_pkg::CNT_W-1:0]         mid_reg;
    logic [sst_pkg::CNT_W-1:0]         dst_reg;
    logic                              hit_reg;
    logic [sst_pkg::VALUE_W-1:0]       hit_val_reg;
    logic [sst_pkg::STATUS_W-1:0]      status_reg;
    logic [sst_pkg::POS_W-1:0]         pos_reg;
    logic [sst_pkg::VALUE_W-1:0]       ev_reg;

    logic [sst_pkg::CNT_W:0]           mid_sum;
    logic [sst_pkg::CNT_W-1:0]         mid;
    logic [sst_pkg::CNT_W-1:0]         src;
    logic                              below;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[sst_pkg::CNT_W:1];
    assign src     = is_del_reg ? (dst_reg + sst_pkg::CNT_W'(1))
                                : (dst_reg - sst_pkg::CNT_W'(1));
    // The one comparator shared by every search step.
    assign below   = $signed(ram_rdata) < val_reg;

    always_comb
    begin
        ram_raddr = '0;
        ram_we    = 1'b0;
        ram_waddr = dst_reg[sst_pkg::IDX_W-1:0];
        ram_wdata = ram_rdata;
        case (state_reg)
            S_IDLE:  ram_raddr = sst_pkg::IDX_W'(cmd.read_index);
            S_SRCH:  ram_raddr = mid[sst_pkg::IDX_W-1:0];
            S_MV_RD: ram_raddr = src[sst_pkg::IDX_W-1:0];
            S_MV_WR: ram_we    = 1'b1;
            S_PUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = lo_reg[sst_pkg::IDX_W-1:0];
                ram_wdata = val_reg;
            end
            default: ram_raddr = '0;
        endcase
    end

    assign stat.busy       = (state_reg != S_IDLE);
    assign stat.done       = (state_reg == S_DONE);
    assign res.status      = status_reg;
    assign res.position    = pos_reg;
    assign res.entry_value = ev_reg;
    assign res.count       = sst_pkg::COUNT_W'(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        val_reg <= cmd.value;
                        ev_reg  <= cmd.value;
                        if (cmd.action == sst_pkg::ACT_READ)
                        begin
                            status_reg <= sst_pkg::ST_READ;
                            pos_reg    <= cmd.read_index;
                            if (32'(cmd.read_index) < 32'(cnt_reg))
                            begin
                                state_reg <= S_RD_WAIT;
                            end
                            else
                            begin
                                ev_reg    <= '0;
                                state_reg <= S_DONE;
                            end
                        end
                        else
                        begin
                            lo_reg    <= '0;
                            hi_reg    <= cnt_reg;
                            hit_reg   <= 1'b0;
                            state_reg <= S_SRCH;
                        end
                    end
                end
                S_RD_WAIT:
                begin
                    ev_reg    <= ram_rdata;
                    state_reg <= S_DONE;
                end
                S_SRCH:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        mid_reg   <= mid;
                        state_reg <= S_CMP;
                    end
                    // The entry at the final place was the last one that
                    // pulled hi down, so its value is already held.
                    else if (hit_reg && (hit_val_reg == val_reg))
                    begin
                        status_reg <= sst_pkg::ST_REMOVED;
                        pos_reg    <= sst_pkg::POS_W'(lo_reg);
                        dst_reg    <= lo_reg;
                        is_del_reg <= 1'b1;
                        if ((32'(lo_reg) + 32'd1) < 32'(cnt_reg))
                        begin
                            state_reg <= S_MV_RD;
                        end
                        else
                        begin
                            cnt_reg   <= cnt_reg - sst_pkg::CNT_W'(1);
                            state_reg <= S_DONE;
                        end
                    end
                    else if (32'(cnt_reg) >= sst_pkg::CAPACITY)
                    begin
                        status_reg <= sst_pkg::ST_FULL;
                        pos_reg    <= '0;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        status_reg <= sst_pkg::ST_INSERTED;
                        pos_reg    <= sst_pkg::POS_W'(lo_reg);
                        dst_reg    <= cnt_reg;
                        is_del_reg <= 1'b0;
                        state_reg  <= (cnt_reg > lo_reg) ? S_MV_RD : S_PUT;
                    end
                end
                S_CMP:
                begin
                    if (below)
                    begin
                        lo_reg <= mid_reg + sst_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        hi_reg      <= mid_reg;
                        hit_reg     <= 1'b1;
                        hit_val_reg <= ram_rdata;
                    end
                    state_reg <= S_SRCH;
                end
                S_MV_RD:
                begin
                    state_reg <= S_MV_WR;
                end
                S_MV_WR:
                begin
                    if (is_del_reg)
                    begin
                        dst_reg <= src;
                        if ((32'(dst_reg) + 32'd2) < 32'(cnt_reg))
                        begin
                            state_reg <= S_MV_RD;
                        end
                        else
                        begin
                            cnt_reg   <= cnt_reg - sst_pkg::CNT_W'(1);
                            state_reg <= S_DONE;
                        end
                    end
                    else
                    begin
                        dst_reg   <= src;
                        state_reg <= (src > lo_reg) ? S_MV_RD : S_PUT;
                    end
                end
                S_PUT:
                begin
                    cnt_reg   <= cnt_reg + sst_pkg::CNT_W'(1);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> src/sorted_set_toggle_core.sv
// ----------------------------------------------------------------------------
// Sorted set toggle core
// Bounded set of signed 32-bit values held in ascending order in a RAM.
// ----------------------------------------------------------------------------
// Usage:
// The cmd channel carries one item per transfer: a toggle (insert the value
// if absent, remove it if present) or a read of the entry at read_index.
// Every item gives exactly one transfer on the rsp channel with status,
// position, value and the count after the item.
// A toggle runs a binary search over the entry RAM: each probe is an address
// step (S_SRCH) and a compare step (S_CMP) with one shared signed comparator,
// and a last S_SRCH step decides. It then moves each entry behind the place
// with a read step and a write step, writes an inserted value in S_PUT and
// hands over the result in S_DONE.
// A read waits for the RAM data in S_RD_WAIT and goes straight to S_DONE
// when read_index is not below the count. The single RAM port pair sets these steps;
// cmd_stall stays high for the whole item, and the next command can be
// taken in the cycle after the result is handed over.
// Reset empties the set at once; the RAM itself is not cleared.
// A finished result sits in the output register while the next command
// is taken; a stalled rsp channel holds the sequencer in its final step.
// ----------------------------------------------------------------------------
module sorted_set_toggle_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  sst_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sst_pkg::rsp_t rsp
);

    sst_pkg::ctrl_stat_t         stat;
    sst_pkg::rsp_t               res;
    sst_pkg::rsp_t               rsp_reg;
    logic                        rsp_valid_reg;
    logic                        res_ready;
    logic                        start;
    logic                        ram_we;
    logic [sst_pkg::IDX_W-1:0]   ram_waddr;
    logic [sst_pkg::VALUE_W-1:0] ram_wdata;
    logic [sst_pkg::IDX_W-1:0]   ram_raddr;
    logic [sst_pkg::VALUE_W-1:0] ram_rdata;

    assign cmd_stall = stat.busy;
    assign start     = cmd_valid && !stat.busy;
    assign res_ready = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    sst_ram #(
        .WIDTH (sst_pkg::VALUE_W),
        .DEPTH (sst_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .res_ready (res_ready),
        .stat      (stat),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (stat.done && res_ready)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    // A taken command keeps the sequencer busy in the next cycle.
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("sequencer not busy after a command transfer");

    // The count never goes beyond the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp.count) <= sst_pkg::CAPACITY))
        else $error("count beyond capacity");

    // An insert is only dropped when the set is full.
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == sst_pkg::ST_FULL))
            |-> (32'(rsp.count) == sst_pkg::CAPACITY))
        else $error("insert dropped while room remains");

    // The sequencer never idles while a result it made is still unsent.
    a_done_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.done && !res_ready) |=> stat.done)
        else $error("result lost while the output register was full");

endmodule

>>> verif/sorted_set_toggle_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set toggle core testbench
// Drives toggle and read commands in bursts against a receiver that stalls on
// a pattern of its own. A scoreboard keeps its own sorted copy of the set,
// predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module sorted_set_toggle_core_tb;

    localparam int ITEM_TARGET  = 1350;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 300;
    localparam int REPORT_MAX   = 10;

    localparam logic signed [sst_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [sst_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef enum int {MIX_PHASE, FILL_PHASE, DRAIN_PHASE} phase_t;

    class sorted_set_scoreboard_t;
        logic signed [sst_pkg::VALUE_W-1:0] held_values[$];
        sst_pkg::rsp_t                      pending_results[$];
        int                                 failures;

        function new();
            failures = 0;
        endfunction

        // Applies one accepted command to the shadow set and queues its result.
        function void take_command(input sst_pkg::cmd_t c);
            sst_pkg::rsp_t                      e;
            logic signed [sst_pkg::VALUE_W-1:0] v;
            int                                 place;
            bit                                 found;
            e = '0;
            v = c.value;
            if (c.action == sst_pkg::ACT_READ)
            begin
                e.status   = sst_pkg::ST_READ;
                e.position = c.read_index;
                e.entry_value = (c.read_index < held_values.size()) ?
                                held_values[c.read_index] : '0;
            end
            else
            begin
                place = held_values.size();
                found = 1'b0;
                for (int i = 0; i < held_values.size(); i++)
                begin
                    if (held_values[i] >= v)
                    begin
                        place = i;
                        found = (held_values[i] == v);
                        break;
                    end
                end
                e.entry_value = v;
                if (found)
                begin
                    held_values.delete(place);
                    e.status   = sst_pkg::ST_REMOVED;
                    e.position = sst_pkg::POS_W'(place);
                end
                else if (held_values.size() >= sst_pkg::CAPACITY)
                begin
                    e.status   = sst_pkg::ST_FULL;
                    e.position = '0;
                end
                else
                begin
                    held_values.insert(place, v);
                    e.status   = sst_pkg::ST_INSERTED;
                    e.position = sst_pkg::POS_W'(place);
                end
            end
            e.count = sst_pkg::COUNT_W'(held_values.size());
            pending_results.push_back(e);
        endfunction

        function void check_result(input sst_pkg::rsp_t r);
            sst_pkg::rsp_t e;
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected result: status %0d pos %0d value %0d count %0d",
                             r.status, r.position, r.entry_value, r.count);
                return;
            end
            e = pending_results.pop_front();
            if (r.status != e.status || r.position != e.position ||
                r.entry_value != e.entry_value || r.count != e.count)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("mismatch: expected status %0d pos %0d value %0d count %0d, %s",
                             e.status, e.position, e.entry_value, e.count,
                             $sformatf("got status %0d pos %0d value %0d count %0d",
                                       r.status, r.position, r.entry_value, r.count));
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           cmd_valid;
    logic           cmd_stall;
    sst_pkg::cmd_t  cmd;
    logic           rsp_valid;
    logic           rsp_stall;
    sst_pkg::rsp_t  rsp;

    sorted_set_scoreboard_t sb;
    int                     burst_left;
    int                     cycle_count;

    sorted_set_toggle_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic sst_pkg::cmd_t toggle_cmd(
        input logic signed [sst_pkg::VALUE_W-1:0] v);
        sst_pkg::cmd_t c;
        c.action     = sst_pkg::ACT_TOGGLE;
        c.value      = v;
        c.read_index = sst_pkg::RIDX_W'($urandom_range(0, sst_pkg::CAPACITY - 1));
        return c;
    endfunction

    function automatic sst_pkg::cmd_t read_cmd(input int idx);
        sst_pkg::cmd_t c;
        c.action     = sst_pkg::ACT_READ;
        c.value      = $urandom;
        c.read_index = sst_pkg::RIDX_W'(idx);
        return c;
    endfunction

    // Most reads land inside the set; the rest may fall anywhere in the
    // index range, including places never written.
    function automatic sst_pkg::cmd_t make_cmd(input phase_t phase);
        sst_pkg::cmd_t                      c;
        int                                 n;
        int                                 pick;
        int                                 read_pct;
        logic signed [sst_pkg::VALUE_W-1:0] v;
        n = sb.held_values.size();
        read_pct = (phase == MIX_PHASE) ? 25 : 10;
        if ($urandom_range(0, 99) < read_pct)
        begin
            if (n > 0 && $urandom_range(0, 3) != 0)
                return read_cmd($urandom_range(0, n - 1));
            else
                return read_cmd($urandom_range(0, (1 << sst_pkg::RIDX_W) - 1));
        end
        pick = $urandom_range(0, 99);
        v = $urandom;
        case (phase)
            FILL_PHASE:
            begin
                if (pick < 5 && n > 0)
                    v = sb.held_values[$urandom_range(0, n - 1)];
            end
            DRAIN_PHASE:
            begin
                if (pick < 85 && n > 0)
                    v = sb.held_values[$urandom_range(0, n - 1)];
            end
            default:
            begin
                if (pick < 30 && n > 0)
                    v = sb.held_values[$urandom_range(0, n - 1)];
                else if (pick < 55)
                    v = int'($urandom_range(0, 12)) - 6;
                else if (pick < 63)
                begin
                    case ($urandom_range(0, 3))
                        0: v = VAL_MIN;
                        1: v = VAL_MAX;
                        2: v = 0;
                        default: v = -1;
                    endcase
                end
                else if (pick < 75 && n > 0)
                    v = sb.held_values[$urandom_range(0, n - 1)] +
                        ($urandom_range(0, 1) ? 1 : -1);
            end
        endcase
        c = toggle_cmd(v);
        return c;
    endfunction

    // Offers one command and returns at the edge where it is transferred.
    task automatic send_item(input sst_pkg::cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(negedge clk);
        while (cmd_stall)
            @(negedge clk);
        @(posedge clk);
        sb.take_command(c);
    endtask

    always @(negedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp);
    end

    // Receiver stall pattern; the fourth segment is a long hold-off that
    // lets the block back up into its command side.
    initial
    begin
        int seg_idx;
        int seg_len;
        int seg_mode;
        int period;
        rsp_stall = 1'b0;
        seg_idx = 0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (seg_idx == 3)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                seg_mode = $urandom_range(0, 3);
                seg_len  = $urandom_range(20, 300);
                period   = $urandom_range(2, 7);
                for (int k = 0; k < seg_len; k++)
                begin
                    case (seg_mode)
                        0: rsp_stall <= 1'b0;
                        1: rsp_stall <= ($urandom_range(0, 99) < 30);
                        2: rsp_stall <= ($urandom_range(0, 99) < 70);
                        default: rsp_stall <= ((k % period) == 0);
                    endcase
                    @(posedge clk);
                end
            end
            seg_idx++;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        sst_pkg::cmd_t directed[$];
        sst_pkg::cmd_t c;
        phase_t        phase;
        int            sent;
        int            left;
        int            phase_no;
        bit            counting;

        sb         = new();
        burst_left = 0;
        cmd_valid  = 1'b0;
        cmd        = '0;
        rst_n      = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, sign ordering, removal of equal values and a read past
        // the count at a place that still holds old data.
        directed.push_back(toggle_cmd(0));
        directed.push_back(toggle_cmd(VAL_MAX));
        directed.push_back(toggle_cmd(VAL_MIN));
        directed.push_back(toggle_cmd(-1));
        directed.push_back(toggle_cmd(1));
        directed.push_back(read_cmd(0));
        directed.push_back(read_cmd(4));
        directed.push_back(toggle_cmd(0));
        directed.push_back(read_cmd(4));
        directed.push_back(read_cmd(2));
        directed.push_back(toggle_cmd(0));
        directed.push_back(toggle_cmd(0));
        directed.push_back(toggle_cmd(VAL_MIN));
        directed.push_back(toggle_cmd(VAL_MAX));
        directed.push_back(toggle_cmd(VAL_MIN + 1));
        directed.push_back(toggle_cmd(VAL_MAX - 1));
        directed.push_back(toggle_cmd(32'sh4000_0000));
        directed.push_back(read_cmd(3));
        directed.push_back(read_cmd(1));
        directed.push_back(toggle_cmd(-1));
        directed.push_back(read_cmd(63));
        foreach (directed[i])
            send_item(directed[i]);

        sent     = 0;
        phase_no = 0;
        while (sent < ITEM_TARGET)
        begin
            case (phase_no)
                0: phase = MIX_PHASE;
                1: phase = FILL_PHASE;
                2: phase = DRAIN_PHASE;
                default: phase = phase_t'($urandom_range(0, 2));
            endcase
            // Fill and drain phases count down only once full or empty.
            left = (phase == MIX_PHASE) ? $urandom_range(40, 160)
                                        : $urandom_range(10, 30);
            while (sent < ITEM_TARGET && left > 0)
            begin
                c = make_cmd(phase);
                send_item(c);
                sent++;
                counting = (phase == MIX_PHASE) ||
                           (phase == FILL_PHASE &&
                            sb.held_values.size() == sst_pkg::CAPACITY) ||
                           (phase == DRAIN_PHASE && sb.held_values.size() == 0);
                if (counting)
                    left--;
            end
            phase_no++;
        end
        cmd_valid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sorted_set_toggle_core.f
src/sst_pkg.sv
src/sst_ram.sv
src/sst_ctrl.sv
src/sorted_set_toggle_core.sv
verif/sorted_set_toggle_core_tb.sv
